// ===== design/fqs_pkg.sv =====
// ----------------------------------------------------------------------------
// fqs_pkg
// shared types and codes for the fifo queue with search
// ----------------------------------------------------------------------------
package fqs_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned CODE_W = 3;

  localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  localparam logic [CODE_W-1:0] RC_PUSHED  = 3'd0;
  localparam logic [CODE_W-1:0] RC_FULL    = 3'd1;
  localparam logic [CODE_W-1:0] RC_POPPED  = 3'd2;
  localparam logic [CODE_W-1:0] RC_EMPTY   = 3'd3;
  localparam logic [CODE_W-1:0] RC_MATCH   = 3'd4;
  localparam logic [CODE_W-1:0] RC_NOMATCH = 3'd5;
  localparam logic [CODE_W-1:0] RC_CLEARED = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_POP  = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

endpackage

// ===== design/fqs_mem.sv =====
// ----------------------------------------------------------------------------
// fqs_mem
// entry storage: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module fqs_mem #(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [AddrW-1:0]               waddr_i,
  input  logic [fqs_pkg::DATA_W-1:0]     wdata_i,
  input  logic                           re_i,
  input  logic [AddrW-1:0]               raddr_i,
  output logic [fqs_pkg::DATA_W-1:0]     rdata_o
);

  logic [fqs_pkg::DATA_W-1:0] mem_q [Depth];
  logic [fqs_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/fifo_queue_with_search_top.sv =====
// ----------------------------------------------------------------------------
// fifo_queue_with_search_top
// fifo queue of signed words in a ring memory, with push, pop, search, clear
// ----------------------------------------------------------------------------
// push, clear, full push and empty pop: result in the cycle after the transaction,
//   next transaction taken in the following cycle
// pop: one memory read, then a registered result; busy while the read data is taken
// search: one memory read per stored entry, busy while scanning (empty: not busy),
//   results one per match in queue order, the last one flagged (none: one no-match)
// reset: asynchronous, queue empty; memory contents are not cleared
// results are strobed for one cycle and cannot be stalled
module fifo_queue_with_search_top #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [fqs_pkg::OP_W-1:0]        opcode_i,
  input  logic signed [fqs_pkg::DATA_W-1:0] data_value_i,
  output logic                            out_valid_o,
  output logic [fqs_pkg::CODE_W-1:0]      result_code_o,
  output logic signed [fqs_pkg::DATA_W-1:0] value_out_o,
  output logic [fqs_pkg::CNT_W-1:0]       position_o,
  output logic [fqs_pkg::CNT_W-1:0]       entry_count_o,
  output logic                            last_result_o
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam logic [fqs_pkg::CNT_W-1:0] FULL_CNT = fqs_pkg::CNT_W'(QUEUE_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);

  function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] p);
    ring_inc = (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  fqs_pkg::state_e state_q, state_d;
  logic [IW-1:0]               head_q, head_d, tail_q, tail_d, rd_ptr_q, rd_ptr_d;
  logic [fqs_pkg::CNT_W-1:0]   count_q, count_d, pos_q, pos_d, pend_pos_q, pend_pos_d;
  logic                        pend_q, pend_d;
  logic [fqs_pkg::DATA_W-1:0]  key_q, key_d;
  logic                        ovalid_q, ovalid_d, last_q, last_d;
  logic [fqs_pkg::CODE_W-1:0]  code_q, code_d;
  logic [fqs_pkg::DATA_W-1:0]  val_q, val_d;
  logic [fqs_pkg::CNT_W-1:0]   opos_q, opos_d;

  logic                        mem_we, mem_re, accept, hit;
  logic [IW-1:0]               mem_waddr, mem_raddr;
  logic [fqs_pkg::DATA_W-1:0]  mem_rdata;

  fqs_mem #(
    .Depth (QUEUE_DEPTH),
    .AddrW (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (data_value_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign busy_o = (state_q != fqs_pkg::S_IDLE);
  assign accept = start_i && !busy_o;
  assign hit    = (mem_rdata == key_q);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    rd_ptr_d   = rd_ptr_q;
    pos_d      = pos_q;
    pend_d     = pend_q;
    pend_pos_d = pend_pos_q;
    key_d      = key_q;
    ovalid_d   = 1'b0;
    code_d     = code_q;
    val_d      = val_q;
    opos_d     = opos_q;
    last_d     = last_q;
    mem_we     = 1'b0;
    mem_waddr  = tail_q;
    mem_re     = 1'b0;
    mem_raddr  = head_q;
    case (state_q)
      fqs_pkg::S_IDLE: begin
        if (accept) begin
          ovalid_d = 1'b1;
          val_d    = '0;
          opos_d   = '0;
          last_d   = 1'b1;
          case (opcode_i)
            fqs_pkg::OP_PUSH: begin
              if (count_q == FULL_CNT) begin
                code_d = fqs_pkg::RC_FULL;
              end else begin
                code_d  = fqs_pkg::RC_PUSHED;
                mem_we  = 1'b1;
                tail_d  = ring_inc(tail_q);
                count_d = count_q + 1'b1;
              end
            end
            fqs_pkg::OP_POP: begin
              if (count_q == '0) begin
                code_d = fqs_pkg::RC_EMPTY;
              end else begin
                ovalid_d = 1'b0;
                mem_re   = 1'b1;
                head_d   = ring_inc(head_q);
                count_d  = count_q - 1'b1;
                state_d  = fqs_pkg::S_POP;
              end
            end
            fqs_pkg::OP_SEARCH: begin
              if (count_q == '0) begin
                code_d = fqs_pkg::RC_NOMATCH;
              end else begin
                ovalid_d = 1'b0;
                mem_re   = 1'b1;
                key_d    = data_value_i;
                rd_ptr_d = ring_inc(head_q);
                pos_d    = fqs_pkg::CNT_W'(1);
                pend_d   = 1'b0;
                state_d  = fqs_pkg::S_SCAN;
              end
            end
            default: begin
              code_d  = fqs_pkg::RC_CLEARED;
              head_d  = '0;
              tail_d  = '0;
              count_d = '0;
            end
          endcase
        end
      end
      fqs_pkg::S_POP: begin
        ovalid_d = 1'b1;
        code_d   = fqs_pkg::RC_POPPED;
        val_d    = mem_rdata;
        opos_d   = '0;
        last_d   = 1'b1;
        state_d  = fqs_pkg::S_IDLE;
      end
      fqs_pkg::S_SCAN: begin
        if (hit) begin
          if (pend_q) begin
            ovalid_d = 1'b1;
            code_d   = fqs_pkg::RC_MATCH;
            val_d    = key_q;
            opos_d   = pend_pos_q;
            last_d   = 1'b0;
          end
          pend_d     = 1'b1;
          pend_pos_d = pos_q;
        end
        if (pos_q == count_q) begin
          state_d = fqs_pkg::S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = rd_ptr_q;
          rd_ptr_d  = ring_inc(rd_ptr_q);
          pos_d     = pos_q + 1'b1;
        end
      end
      fqs_pkg::S_DONE: begin
        ovalid_d = 1'b1;
        last_d   = 1'b1;
        if (pend_q) begin
          code_d = fqs_pkg::RC_MATCH;
          val_d  = key_q;
          opos_d = pend_pos_q;
        end else begin
          code_d = fqs_pkg::RC_NOMATCH;
          val_d  = '0;
          opos_d = '0;
        end
        state_d = fqs_pkg::S_IDLE;
      end
      default: begin
        state_d = fqs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fqs_pkg::S_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      pend_q   <= pend_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q   <= rd_ptr_d;
    pos_q      <= pos_d;
    pend_pos_q <= pend_pos_d;
    key_q      <= key_d;
    code_q     <= code_d;
    val_q      <= val_d;
    opos_q     <= opos_d;
    last_q     <= last_d;
  end

  assign out_valid_o   = ovalid_q;
  assign result_code_o = code_q;
  assign value_out_o   = val_q;
  assign position_o    = opos_q;
  assign entry_count_o = count_q;
  assign last_result_o = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("occupancy above queue depth");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && opcode_i == fqs_pkg::OP_PUSH && count_q != FULL_CNT)
    |=> (count_q == $past(count_q) + 1'b1) && out_valid_o)
    else $error("push did not grow the queue");

  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && opcode_i == fqs_pkg::OP_POP && count_q != '0)
    |=> ##1 (out_valid_o && result_code_o == fqs_pkg::RC_POPPED && last_result_o))
    else $error("pop result missing");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fqs_pkg::S_DONE) |=> (out_valid_o && last_result_o && !busy_o))
    else $error("search did not close with a final result");

  a_scan_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fqs_pkg::S_SCAN) |-> (pos_q != '0 && pos_q <= count_q))
    else $error("scan position out of range");

endmodule
